FILE: hdl/ltre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_pkg
// Shared types, sizes and helpers of the trie row engine.
// ----------------------------------------------------------------------------
package ltre_pkg;

  localparam int MAX_QUERY = 16;
  localparam int MAX_DEPTH = 64;

  localparam int LETTER_W = 6;
  localparam int DEPTH_W  = 7;
  localparam int FREQ_W   = 32;
  localparam int VAL_W    = 7;
  localparam int QLEN_W   = 5;
  localparam int QWORD_W  = 64;
  localparam int QBYTE_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] CELL_MAX = 7'd127;

  // cell counter reaches MAX_QUERY + 1 during prefetch
  localparam int CELL_W = $clog2(MAX_QUERY + 2);
  localparam int ROW_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ADDR_W = ROW_W + CELL_W;
  localparam int LIDX_W = $clog2(2 * QWORD_W / QBYTE_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LENGTH  = 2'd0,
    REG_MAX_DISTANCE  = 2'd1,
    REG_QUERY_LETTERS0 = 2'd2,
    REG_QUERY_LETTERS1 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic first;   // cell 0 of the row
    logic hit;     // query letter equals node letter
  } cell_op_t;

  // row store index of a node depth: depth 0 acts as 1, deep nodes clamp
  function automatic logic [ROW_W-1:0] depth_idx(input logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W:0] d;
    d = {1'b0, depth};
    if (d == '0) begin
      d = (DEPTH_W+1)'(1);
    end
    if (d > (DEPTH_W+1)'(MAX_DEPTH)) begin
      d = (DEPTH_W+1)'(MAX_DEPTH);
    end
    d = d - (DEPTH_W+1)'(1);
    return d[ROW_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] sat_len(input logic [QLEN_W-1:0] qlen);
    logic [CELL_W-1:0] n;
    if ({1'b0, qlen} > (QLEN_W+1)'(MAX_QUERY)) begin
      n = CELL_W'(MAX_QUERY);
    end else begin
      n = CELL_W'(qlen);
    end
    return n;
  endfunction

endpackage

FILE: hdl/ltre_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_in_if
// Node channel: one trie node per word.
// ----------------------------------------------------------------------------
interface ltre_in_if;
  logic                          valid;
  logic                          ready;
  logic [ltre_pkg::LETTER_W-1:0] node_letter;
  logic [ltre_pkg::DEPTH_W-1:0]  node_depth;
  logic                          node_terminal;
  logic [ltre_pkg::FREQ_W-1:0]   node_frequency;

  modport source (output valid, node_letter, node_depth, node_terminal, node_frequency,
                  input ready);
  modport sink (input valid, node_letter, node_depth, node_terminal, node_frequency,
                output ready);
endinterface

FILE: hdl/ltre_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_out_if
// Result channel: distance, match flag and frequency per word.
// ----------------------------------------------------------------------------
interface ltre_out_if;
  logic                        valid;
  logic                        ready;
  logic [ltre_pkg::VAL_W-1:0]  edit_distance;
  logic                        word_match;
  logic [ltre_pkg::FREQ_W-1:0] match_frequency;

  modport source (output valid, edit_distance, word_match, match_frequency,
                  input ready);
  modport sink (input valid, edit_distance, word_match, match_frequency,
                output ready);
endinterface

FILE: hdl/ltre_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_row_mem
// Row store for depths 1..MAX_DEPTH, one cell per entry, registered read.
// ----------------------------------------------------------------------------
module ltre_row_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ltre_pkg::ADDR_W-1:0] waddr,
  input  logic [ltre_pkg::VAL_W-1:0]  wdata,
  input  logic [ltre_pkg::ADDR_W-1:0] raddr,
  output logic [ltre_pkg::VAL_W-1:0]  rdata
);

  logic [ltre_pkg::VAL_W-1:0] mem [2**ltre_pkg::ADDR_W];
  logic [ltre_pkg::VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ltre_cell_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_cell_unit
// One edit-distance cell: diagonal on a hit, else 1 + min of three (1 + up for cell 0), saturating.
// ----------------------------------------------------------------------------
module ltre_cell_unit (
  input  ltre_pkg::cell_op_t         op,
  input  logic [ltre_pkg::VAL_W-1:0] up,
  input  logic [ltre_pkg::VAL_W-1:0] left,
  input  logic [ltre_pkg::VAL_W-1:0] diag,
  output logic [ltre_pkg::VAL_W-1:0] cell_value
);

  logic [ltre_pkg::VAL_W-1:0] m;

  always_comb begin
    m = up;
    if (!op.first) begin
      if (left < m) begin
        m = left;
      end
      if (diag < m) begin
        m = diag;
      end
    end
    if (!op.first && op.hit) begin
      cell_value = diag;
    end else if (m >= ltre_pkg::CELL_MAX) begin
      cell_value = ltre_pkg::CELL_MAX;
    end else begin
      cell_value = m + ltre_pkg::VAL_W'(1);
    end
  end

endmodule

FILE: hdl/levenshtein_trie_row_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// levenshtein_trie_row_engine_top
// Edit-distance row engine for a fuzzy trie walk against a configured query.
// ----------------------------------------------------------------------------
// Each trie node word (depth-first order) goes through these steps in order,
// with n the query length clamped to 16: it is accepted while cell 0 of the
// parent row is prefetched; the shared cell unit computes cells 0 to n, one
// cell per cycle (the left-neighbor dependency chains the cells, and the row
// store's single read port delivers one parent cell per cycle); then the
// result is handed to the output register, waiting while that register holds
// an untaken result. The input is not ready while a node is in work; a
// finished result may wait in the output register while the next node is
// taken. Row 0 is a constant 0,1,2,.. and is never stored, so there is no
// clearing pass after reset. Rows of depths that were never written read
// back undefined. Configuration must be written only while the engine is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module levenshtein_trie_row_engine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  ltre_in_if.sink                        in_ch,
  ltre_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ltre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ltre_pkg::QWORD_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // configuration registers
  logic [ltre_pkg::QLEN_W-1:0]  qlen_r;
  logic [ltre_pkg::VAL_W-1:0]   maxd_r;
  logic [ltre_pkg::QWORD_W-1:0] qlet0_r;
  logic [ltre_pkg::QWORD_W-1:0] qlet1_r;

  // sequencer
  state_t                       state_r, state_nxt;
  logic [ltre_pkg::CELL_W-1:0]  cnt_r, cnt_nxt;
  logic [ltre_pkg::CELL_W-1:0]  n_r;

  // node held during the row pass
  logic [ltre_pkg::ROW_W-1:0]    row_idx_r;
  logic                          row_one_r;   // parent is the constant row 0
  logic [ltre_pkg::LETTER_W-1:0] letter_r;
  logic                          terminal_r;
  logic [ltre_pkg::FREQ_W-1:0]   freq_r;
  logic [ltre_pkg::VAL_W-1:0]    left_r;
  logic [ltre_pkg::VAL_W-1:0]    diag_r;
  logic [ltre_pkg::VAL_W-1:0]    dist_r;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [ltre_pkg::VAL_W-1:0]    out_dist_r;
  logic                          out_match_r;
  logic [ltre_pkg::FREQ_W-1:0]   out_freq_r;

  logic                          in_accept;
  logic                          load_out;
  logic                          mem_we;
  logic [ltre_pkg::ADDR_W-1:0]   mem_waddr;
  logic [ltre_pkg::ADDR_W-1:0]   mem_raddr;
  logic [ltre_pkg::VAL_W-1:0]    mem_rdata;
  logic [ltre_pkg::ROW_W-1:0]    in_row_idx;
  logic [ltre_pkg::VAL_W-1:0]    up_val;
  logic [ltre_pkg::VAL_W-1:0]    cell_val;
  ltre_pkg::cell_op_t            cell_op;
  logic [2*ltre_pkg::QWORD_W-1:0] qword;
  logic [ltre_pkg::CELL_W-1:0]   lidx_full;
  logic [ltre_pkg::LIDX_W-1:0]   lidx;
  logic [ltre_pkg::QBYTE_W-1:0]  qbyte;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_row_idx  = ltre_pkg::depth_idx(in_ch.node_depth);

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r  <= '0;
      maxd_r  <= '0;
      qlet0_r <= '0;
      qlet1_r <= '0;
    end else if (cfg_we) begin
      unique case (ltre_pkg::cfg_reg_t'(cfg_index))
        ltre_pkg::REG_QUERY_LENGTH:   qlen_r  <= cfg_wdata[ltre_pkg::QLEN_W-1:0];
        ltre_pkg::REG_MAX_DISTANCE:   maxd_r  <= cfg_wdata[ltre_pkg::VAL_W-1:0];
        ltre_pkg::REG_QUERY_LETTERS0: qlet0_r <= cfg_wdata;
        ltre_pkg::REG_QUERY_LETTERS1: qlet1_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- row store ----
  // Parent cells are prefetched through the registered read: cell 0 while idle,
  // cell k+1 while cell k is computed. Writes go to the node's own row.
  always_comb begin
    if (state_r == ST_IDLE) begin
      mem_raddr = {in_row_idx - ltre_pkg::ROW_W'(1), ltre_pkg::CELL_W'(0)};
    end else begin
      mem_raddr = {row_idx_r - ltre_pkg::ROW_W'(1), cnt_r + ltre_pkg::CELL_W'(1)};
    end
  end

  assign mem_we    = (state_r == ST_CALC);
  assign mem_waddr = {row_idx_r, cnt_r};

  ltre_row_mem u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cell_val),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---- cell datapath ----
  // Query letter for cell k is letter k-1.
  assign qword     = {qlet1_r, qlet0_r};
  assign lidx_full = cnt_r - ltre_pkg::CELL_W'(1);
  assign lidx      = lidx_full[ltre_pkg::LIDX_W-1:0];
  assign qbyte     = qword[lidx*ltre_pkg::QBYTE_W +: ltre_pkg::QBYTE_W];

  assign up_val        = row_one_r ? ltre_pkg::VAL_W'(cnt_r) : mem_rdata;
  assign cell_op.first = (cnt_r == '0);
  assign cell_op.hit   = ({{(ltre_pkg::QBYTE_W-ltre_pkg::LETTER_W){1'b0}}, letter_r} == qbyte);

  ltre_cell_unit u_cell (
    .op         (cell_op),
    .up         (up_val),
    .left       (left_r),
    .diag       (diag_r),
    .cell_value (cell_val)
  );

  // ---- sequencer ----
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CALC;
          cnt_nxt   = '0;
        end
      end
      ST_CALC: begin
        cnt_nxt = cnt_r + ltre_pkg::CELL_W'(1);
        if (cnt_r == n_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // node and row-pass payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      n_r        <= ltre_pkg::sat_len(qlen_r);
      row_idx_r  <= in_row_idx;
      row_one_r  <= (in_row_idx == '0);
      letter_r   <= in_ch.node_letter;
      terminal_r <= in_ch.node_terminal;
      freq_r     <= in_ch.node_frequency;
    end
    if (state_r == ST_CALC) begin
      left_r <= cell_val;
      diag_r <= up_val;
      if (cnt_r == n_r) begin
        dist_r <= cell_val;
      end
    end
    if (load_out) begin
      out_dist_r  <= dist_r;
      out_match_r <= terminal_r && (dist_r <= maxd_r);
      out_freq_r  <= freq_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.edit_distance   = out_dist_r;
  assign out_ch.word_match      = out_match_r;
  assign out_ch.match_frequency = out_freq_r;

  // ---- assertions ----
  a_accept_starts_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_CALC) && (cnt_r == '0))
    else $error("accepted node did not start a row pass at cell 0");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (cnt_r <= n_r))
    else $error("cell counter ran past the query length");

  a_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) && (cnt_r == n_r) |=> (state_r == ST_DONE))
    else $error("row pass did not finish after the last cell");

  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over an untaken result");

endmodule
